>>> src/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, codes and calendar functions for the Gregorian date core.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int unsigned MaxYearDefault = 9999;
  localparam int unsigned YearW = 15;
  localparam int unsigned SerW  = 25;

  typedef enum logic [1:0] {
    MODE_ADD  = 2'd0,
    MODE_SUB  = 2'd1,
    MODE_DIFF = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2,
    ST_UNUSED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    YS_Y1   = 2'd0,
    YS_Y2   = 2'd1,
    YS_CAND = 2'd2,
    YS_YR   = 2'd3
  } ys_sel_t;

  typedef struct packed {
    logic       load;
    logic       ys_en;
    ys_sel_t    ys_sel;
    logic       ser1;
    logic       ser2;
    logic       adj;
    logic       search_init;
    logic       search_step;
    logic       finish;
    logic [3:0] bit_idx;
  } gda_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  bad_date;
    logic  out_busy;
  } gda_sts_t;

  function automatic logic [YearW-1:0] div100(input logic [YearW-1:0] x);
    logic [28:0] p;
    begin
      p = 29'(x) * 29'd5243;
      return YearW'(p[28:19]);
    end
  endfunction

  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] q;
    logic [YearW-1:0] r;
    begin
      q = div100(y);
      r = y - q * 15'd100;
      return (y[1:0] == 2'b00 && r != '0) || (r == '0 && q[1:0] == 2'b00);
    end
  endfunction

  function automatic logic [SerW-1:0] year_start(input logic [YearW-1:0] y);
    logic [YearW-1:0] t;
    logic [SerW-1:0]  v;
    begin
      t = y - 15'd1;
      v = SerW'(y) * 25'd365 + SerW'(t >> 2) - SerW'(div100(t))
          + SerW'(div100(t >> 2)) + 25'd1;
      if (y == '0) v = '0;
      return v;
    end
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] v;
    begin
      case (m)
        4'd2:    v = 9'd31;
        4'd3:    v = 9'd59;
        4'd4:    v = 9'd90;
        4'd5:    v = 9'd120;
        4'd6:    v = 9'd151;
        4'd7:    v = 9'd181;
        4'd8:    v = 9'd212;
        4'd9:    v = 9'd243;
        4'd10:   v = 9'd273;
        4'd11:   v = 9'd304;
        4'd12:   v = 9'd334;
        default: v = 9'd0;
      endcase
      return v;
    end
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] v;
    begin
      case (m)
        4'd2:    v = leap ? 5'd29 : 5'd28;
        4'd4:    v = 5'd30;
        4'd6:    v = 5'd30;
        4'd9:    v = 5'd30;
        4'd11:   v = 5'd30;
        default: v = 5'd31;
      endcase
      return v;
    end
  endfunction

  function automatic logic date_ok(input logic [4:0] d, input logic [3:0] m,
                                   input logic [13:0] y);
    begin
      return m >= 4'd1 && m <= 4'd12 && d >= 5'd1 &&
             d <= month_len(m, is_leap({1'b0, y}));
    end
  endfunction

endpackage

>>> src/gda_ctrl.sv
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer that steps the date datapath through conversion and year search.
// ----------------------------------------------------------------------------
module gda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  gda_pkg::gda_sts_t sts,
  output gda_pkg::gda_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_YS1  = 10'b0000000010,
    S_SER1 = 10'b0000000100,
    S_YS2  = 10'b0000001000,
    S_SER2 = 10'b0000010000,
    S_ADJ  = 10'b0000100000,
    S_YSC  = 10'b0001000000,
    S_CMP  = 10'b0010000000,
    S_YSF  = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r;
    cmd       = '0;
    cmd.ys_sel  = gda_pkg::YS_Y1;
    cmd.bit_idx = bit_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) state_nxt = S_YS1;
      end
      S_YS1: begin
        cmd.ys_en  = 1'b1;
        cmd.ys_sel = gda_pkg::YS_Y1;
        if (sts.mode == gda_pkg::MODE_NONE || sts.bad_date) state_nxt = S_FIN;
        else state_nxt = S_SER1;
      end
      S_SER1: begin
        cmd.ser1 = 1'b1;
        state_nxt = (sts.mode == gda_pkg::MODE_DIFF) ? S_YS2 : S_ADJ;
      end
      S_YS2: begin
        cmd.ys_en  = 1'b1;
        cmd.ys_sel = gda_pkg::YS_Y2;
        state_nxt  = S_SER2;
      end
      S_SER2: begin
        cmd.ser2  = 1'b1;
        state_nxt = S_FIN;
      end
      S_ADJ: begin
        cmd.adj         = 1'b1;
        cmd.search_init = 1'b1;
        bit_nxt         = 4'(gda_pkg::YearW - 1);
        state_nxt       = S_YSC;
      end
      S_YSC: begin
        cmd.ys_en  = 1'b1;
        cmd.ys_sel = gda_pkg::YS_CAND;
        state_nxt  = S_CMP;
      end
      S_CMP: begin
        cmd.search_step = 1'b1;
        if (bit_r == '0) begin
          state_nxt = S_YSF;
        end else begin
          bit_nxt   = bit_r - 4'd1;
          state_nxt = S_YSC;
        end
      end
      S_YSF: begin
        cmd.ys_en  = 1'b1;
        cmd.ys_sel = gda_pkg::YS_YR;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !sts.out_busy) else $error("finish while output occupied");
  a_cmp_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && bit_r == '0) |=> state_r == S_YSF)
    else $error("year search did not end");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_YS1) else $error("load outside idle");

endmodule

>>> src/gda_dp.sv
// ----------------------------------------------------------------------------
// gda_dp
// Datapath: serial day conversion, offset, bitwise year search, result word.
// ----------------------------------------------------------------------------
module gda_dp #(
  parameter int unsigned MAX_YEAR = gda_pkg::MaxYearDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gda_pkg::gda_cmd_t  cmd,
  output gda_pkg::gda_sts_t  sts,
  input  logic [1:0]         in_mode,
  input  logic [4:0]         in_day,
  input  logic [3:0]         in_month,
  input  logic [13:0]        in_year,
  input  logic [4:0]         in_other_day,
  input  logic [3:0]         in_other_month,
  input  logic [13:0]        in_other_year,
  input  logic [19:0]        in_offset_days,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_result_day,
  output logic [3:0]         out_result_month,
  output logic [13:0]        out_result_year,
  output logic signed [22:0] out_day_difference,
  output logic [1:0]         out_status
);

  localparam int unsigned YW = gda_pkg::YearW;
  localparam int unsigned SW = gda_pkg::SerW;

  gda_pkg::mode_t mode_r;
  logic [4:0]     d1_r, d2_r;
  logic [3:0]     m1_r, m2_r;
  logic [13:0]    y1_r, y2_r;
  logic [19:0]    off_r;
  logic [SW-1:0]  ys_r;
  logic [SW-1:0]  s1_r, s2_r, s_r;
  logic [YW-1:0]  y_r;
  logic           out_valid_r;
  logic [4:0]     out_day_r;
  logic [3:0]     out_month_r;
  logic [13:0]    out_year_r;
  logic [22:0]    out_diff_r;
  logic [1:0]     out_status_r;

  logic [YW-1:0]  cand;
  logic [YW-1:0]  ys_arg;
  logic           bad_date;
  logic [4:0]     ser_d;
  logic [3:0]     ser_m;
  logic [YW-1:0]  ser_y;
  logic [SW-1:0]  ser_val;
  logic [SW-1:0]  diff;
  logic [22:0]    diff_sat;
  logic [SW-1:0]  rem_full;
  logic [8:0]     rem;
  logic           leap_y;
  logic [3:0]     fm;
  logic [8:0]     fcum;
  logic [8:0]     cum_k;
  logic           range_bad;
  logic [4:0]     f_day;
  logic [3:0]     f_month;
  logic [13:0]    f_year;
  logic [22:0]    f_diff;
  logic [1:0]     f_status;

  assign cand = y_r | (YW'(1) << cmd.bit_idx);

  always_comb begin
    case (cmd.ys_sel)
      gda_pkg::YS_Y1:   ys_arg = {1'b0, y1_r};
      gda_pkg::YS_Y2:   ys_arg = {1'b0, y2_r};
      gda_pkg::YS_CAND: ys_arg = cand;
      gda_pkg::YS_YR:   ys_arg = y_r;
      default:          ys_arg = y_r;
    endcase
  end

  assign bad_date = !gda_pkg::date_ok(d1_r, m1_r, y1_r) ||
                    (mode_r == gda_pkg::MODE_DIFF && !gda_pkg::date_ok(d2_r, m2_r, y2_r));

  assign ser_d = cmd.ser2 ? d2_r : d1_r;
  assign ser_m = cmd.ser2 ? m2_r : m1_r;
  assign ser_y = cmd.ser2 ? {1'b0, y2_r} : {1'b0, y1_r};
  assign ser_val = ys_r + SW'(gda_pkg::days_before(ser_m)) + SW'(ser_d)
                   + SW'(ser_m > 4'd2 && gda_pkg::is_leap(ser_y)) - SW'(1);

  assign diff = s1_r - s2_r;
  always_comb begin
    if (!diff[SW-1] && diff > SW'(23'h3FFFFF)) diff_sat = 23'h3FFFFF;
    else if (diff[SW-1] && $signed(diff) < -25'sd4194304) diff_sat = 23'h400000;
    else diff_sat = diff[22:0];
  end

  assign rem_full = s_r - ys_r;
  assign rem      = rem_full[8:0];
  assign leap_y   = gda_pkg::is_leap(y_r);

  always_comb begin
    fm   = 4'd1;
    fcum = '0;
    for (int k = 2; k <= 12; k++) begin
      cum_k = gda_pkg::days_before(4'(k)) + 9'(k > 2 && leap_y);
      if (rem >= cum_k) begin
        fm   = 4'(k);
        fcum = cum_k;
      end
    end
  end

  assign range_bad = (y_r == '0) || ({2'b00, y_r} > 17'(MAX_YEAR)) ||
                     (y_r > YW'(16383));

  always_comb begin
    f_day    = '0;
    f_month  = '0;
    f_year   = '0;
    f_diff   = '0;
    f_status = gda_pkg::ST_OK;
    if (mode_r == gda_pkg::MODE_NONE) begin
      f_status = gda_pkg::ST_OK;
    end else if (bad_date) begin
      f_status = gda_pkg::ST_BAD_DATE;
    end else if (mode_r == gda_pkg::MODE_DIFF) begin
      f_diff = diff_sat;
    end else if (s_r[SW-1] || range_bad) begin
      f_status = gda_pkg::ST_RANGE;
    end else begin
      f_day   = 5'(rem - fcum + 9'd1);
      f_month = fm;
      f_year  = y_r[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= gda_pkg::mode_t'(in_mode);
      d1_r   <= in_day;
      m1_r   <= in_month;
      y1_r   <= in_year;
      d2_r   <= in_other_day;
      m2_r   <= in_other_month;
      y2_r   <= in_other_year;
      off_r  <= in_offset_days;
    end
    if (cmd.ys_en) ys_r <= gda_pkg::year_start(ys_arg);
    if (cmd.ser1) s1_r <= ser_val;
    if (cmd.ser2) s2_r <= ser_val;
    if (cmd.adj) begin
      if (mode_r == gda_pkg::MODE_SUB) s_r <= s1_r - SW'(off_r);
      else s_r <= s1_r + SW'(off_r);
    end
    if (cmd.search_init) y_r <= '0;
    else if (cmd.search_step && ys_r <= s_r) y_r <= cand;
    if (cmd.finish) begin
      out_day_r    <= f_day;
      out_month_r  <= f_month;
      out_year_r   <= f_year;
      out_diff_r   <= f_diff;
      out_status_r <= f_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  assign sts.mode     = mode_r;
  assign sts.bad_date = bad_date;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid          = out_valid_r;
  assign out_result_day     = out_day_r;
  assign out_result_month   = out_month_r;
  assign out_result_year    = out_year_r;
  assign out_day_difference = $signed(out_diff_r);
  assign out_status         = out_status_r;

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_status_r != gda_pkg::ST_UNUSED) else $error("bad status code");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != gda_pkg::ST_OK) |->
    (out_day_r == '0 && out_month_r == '0 && out_diff_r == '0))
    else $error("nonzero fields on error word");
  a_search_init: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search_init |=> y_r == '0) else $error("year search not cleared");

endmodule

>>> src/gregorian_date_arithmetic_core.sv
// An illegal date or unused mode goes from the first year start straight to the result.
// A difference converts both dates to serial day numbers and subtracts them.
// Add and subtract apply the offset and then run the 15-step bitwise year search.
// One word in work at a time: the next enters once the last reaches the result register.
// A result register lets the next word enter while a result waits.
// Reset (rst_n, synchronous, active low) returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_core
// Gregorian date add, subtract and day difference with date checking.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic_core #(
  parameter int unsigned MAX_YEAR = gda_pkg::MaxYearDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [4:0]         in_day,
  input  logic [3:0]         in_month,
  input  logic [13:0]        in_year,
  input  logic [4:0]         in_other_day,
  input  logic [3:0]         in_other_month,
  input  logic [13:0]        in_other_year,
  input  logic [19:0]        in_offset_days,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_result_day,
  output logic [3:0]         out_result_month,
  output logic [13:0]        out_result_year,
  output logic signed [22:0] out_day_difference,
  output logic [1:0]         out_status
);

  gda_pkg::gda_cmd_t cmd;
  gda_pkg::gda_sts_t sts;

  gda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gda_dp #(
    .MAX_YEAR (MAX_YEAR)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_mode            (in_mode),
    .in_day             (in_day),
    .in_month           (in_month),
    .in_year            (in_year),
    .in_other_day       (in_other_day),
    .in_other_month     (in_other_month),
    .in_other_year      (in_other_year),
    .in_offset_days     (in_offset_days),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_day     (out_result_day),
    .out_result_month   (out_result_month),
    .out_result_year    (out_result_year),
    .out_day_difference (out_day_difference),
    .out_status         (out_status)
  );

endmodule
